@@ rtl/leb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants and operation codes for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int BufDepth = 256;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int PosW     = AddrW + 1;
  localparam int CharW    = 8;
  localparam int OpW      = 3;

  localparam logic [PosW-1:0] CapReset = PosW'(256);

  typedef enum logic [OpW-1:0] {
    OP_PUT       = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_LEFT      = 3'd2,
    OP_RIGHT     = 3'd3,
    OP_MOVE_TO   = 3'd4,
    OP_MOVE_END  = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_READ      = 3'd7
  } op_t;

endpackage

@@ rtl/line_edit_buffer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer
// Text buffer with a cursor, byte store in a one-port-read, one-port-write RAM.
// ----------------------------------------------------------------------------
// Sequence: an accepted input passes the exec, read-issue and capture states,
//   then the done state registers the result once the output is free; a
//   backspace inside the text first shifts the (length - cursor) tail bytes down.
// Flow: one transaction in flight; the next is accepted once the sequencer is
//   back in idle. The tail shift is bound by the RAM read port.
// Reset: cursor, length and status clear, capacity returns to 256; the store
//   is not cleared and needs no sweep.
module line_edit_buffer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [leb_pkg::OpW-1:0]       operation,
  input  logic [leb_pkg::CharW-1:0]     char_code,
  input  logic [leb_pkg::PosW-1:0]      index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic [leb_pkg::PosW-1:0]      cursor_now,
  output logic [leb_pkg::PosW-1:0]      length_now,
  output logic [leb_pkg::CharW-1:0]     char_before,
  output logic [leb_pkg::CharW-1:0]     read_byte,
  output logic                          at_end,
  input  logic                          capacity_we,
  input  logic [leb_pkg::PosW-1:0]      capacity_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_CB_ISSUE,
    S_CB_CAP,
    S_DONE
  } state_t;

  state_t                        state;
  leb_pkg::op_t                  op_q;
  logic [leb_pkg::CharW-1:0]     char_q;
  logic [leb_pkg::PosW-1:0]      index_q;
  logic [leb_pkg::PosW-1:0]      cursor_pos;
  logic [leb_pkg::PosW-1:0]      text_length;
  logic [leb_pkg::PosW-1:0]      capacity;
  logic [leb_pkg::AddrW-1:0]     ptr;
  logic                          ok_q;
  logic                          rd_pend;
  logic [leb_pkg::CharW-1:0]     read_q;
  logic [leb_pkg::CharW-1:0]     before_q;

  logic [leb_pkg::CharW-1:0]     text_store [leb_pkg::BufDepth];
  logic                          mem_we;
  logic [leb_pkg::AddrW-1:0]     mem_waddr;
  logic [leb_pkg::CharW-1:0]     mem_wdata;
  logic [leb_pkg::AddrW-1:0]     mem_raddr;
  logic [leb_pkg::CharW-1:0]     mem_rdata;

  logic                          put_ok;
  logic [leb_pkg::PosW-1:0]      cursor_dec;
  logic [leb_pkg::PosW-1:0]      ptr_inc;
  logic                          out_free;

  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign cursor_dec = cursor_pos - leb_pkg::PosW'(1);
  assign ptr_inc    = {1'b0, ptr} + leb_pkg::PosW'(1);
  assign put_ok     = (cursor_pos < capacity) &&
                      (cursor_pos < leb_pkg::PosW'(leb_pkg::BufDepth));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor_pos[leb_pkg::AddrW-1:0];
    mem_wdata = char_q;
    mem_raddr = cursor_dec[leb_pkg::AddrW-1:0];
    case (state)
      S_EXEC: begin
        if (op_q == leb_pkg::OP_PUT && put_ok) begin
          mem_we = 1'b1;
        end
        if (op_q == leb_pkg::OP_READ) begin
          mem_raddr = index_q[leb_pkg::AddrW-1:0];
        end else begin
          mem_raddr = cursor_pos[leb_pkg::AddrW-1:0];
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        mem_raddr = ptr + leb_pkg::AddrW'(2);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= text_store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cursor_pos  <= '0;
      text_length <= '0;
      capacity    <= leb_pkg::CapReset;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_data;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= leb_pkg::op_t'(operation);
            char_q  <= char_code;
            index_q <= index;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          ok_q    <= 1'b0;
          read_q  <= '0;
          rd_pend <= 1'b0;
          state   <= S_CB_ISSUE;
          case (op_q)
            leb_pkg::OP_PUT: begin
              if (put_ok) begin
                ok_q       <= 1'b1;
                cursor_pos <= cursor_pos + leb_pkg::PosW'(1);
                if (cursor_pos == text_length) begin
                  text_length <= text_length + leb_pkg::PosW'(1);
                end
              end
            end
            leb_pkg::OP_BACKSPACE: begin
              if (cursor_pos != '0) begin
                ok_q        <= 1'b1;
                cursor_pos  <= cursor_dec;
                text_length <= text_length - leb_pkg::PosW'(1);
                ptr         <= cursor_dec[leb_pkg::AddrW-1:0];
                if (cursor_pos < text_length) begin
                  state <= S_SHIFT;
                end
              end
            end
            leb_pkg::OP_LEFT: begin
              if (cursor_pos != '0) begin
                ok_q       <= 1'b1;
                cursor_pos <= cursor_dec;
              end
            end
            leb_pkg::OP_RIGHT: begin
              if (cursor_pos < text_length) begin
                ok_q       <= 1'b1;
                cursor_pos <= cursor_pos + leb_pkg::PosW'(1);
              end
            end
            leb_pkg::OP_MOVE_TO: begin
              if (index_q <= text_length) begin
                ok_q       <= 1'b1;
                cursor_pos <= index_q;
              end
            end
            leb_pkg::OP_MOVE_END: begin
              ok_q       <= 1'b1;
              cursor_pos <= text_length;
            end
            leb_pkg::OP_CLEAR: begin
              ok_q        <= 1'b1;
              cursor_pos  <= '0;
              text_length <= '0;
            end
            leb_pkg::OP_READ: begin
              ok_q    <= 1'b1;
              rd_pend <= (index_q < text_length);
            end
            default: begin
              ok_q <= 1'b0;
            end
          endcase
        end
        S_SHIFT: begin
          // advance while the moved tail still reaches the new length
          if (ptr_inc < text_length) begin
            ptr <= ptr + leb_pkg::AddrW'(1);
          end else begin
            state <= S_CB_ISSUE;
          end
        end
        S_CB_ISSUE: begin
          if (rd_pend) begin
            read_q <= mem_rdata;
          end
          state <= S_CB_CAP;
        end
        S_CB_CAP: begin
          before_q <= (cursor_pos == '0) ? '0 : mem_rdata;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            ok          <= ok_q;
            cursor_now  <= cursor_pos;
            length_now  <= text_length;
            char_before <= before_q;
            read_byte   <= read_q;
            at_end      <= (cursor_pos == text_length);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    cursor_pos <= text_length)
    else $error("cursor beyond text length");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    text_length <= leb_pkg::PosW'(leb_pkg::BufDepth))
    else $error("text length beyond store depth");

  a_shift_in_text: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (ptr_inc <= text_length))
    else $error("tail shift writes beyond text");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted transaction did not start");

endmodule
